// ----- hdl/mp2p_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2p_pkg
// Shared types, record codes and lookup tables of the Layer II header and
// side-info parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mp2p_pkg;

  localparam logic [1:0] REC_HEADER = 2'd0;
  localparam logic [1:0] REC_BAND   = 2'd1;
  localparam logic [1:0] REC_ERROR  = 2'd2;

  localparam logic [1:0] MODE_JOINT = 2'd1;
  localparam logic [1:0] MODE_MONO  = 2'd3;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [10:0] frame_bytes;
    logic [1:0]  stereo_mode;
    logic [4:0]  subband_count;
    logic [4:0]  intensity_bound;
    logic [4:0]  band_index;
    logic        channel_index;
    logic [4:0]  quant_class;
    logic [5:0]  scale_first;
    logic [5:0]  scale_second;
    logic [5:0]  scale_third;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic rec_valid;
  } stat_t;

  // Frame length 144000*kbps/rate, per sample-rate code and bitrate code.
  function automatic logic [10:0] frame_len(input logic [1:0] rc, input logic [3:0] br);
    logic [10:0] l44;
    logic [10:0] l48;
    logic [10:0] l32;
    case (br)
      4'd1:  begin l44 = 11'd104;  l48 = 11'd96;   l32 = 11'd144;  end
      4'd2:  begin l44 = 11'd156;  l48 = 11'd144;  l32 = 11'd216;  end
      4'd3:  begin l44 = 11'd182;  l48 = 11'd168;  l32 = 11'd252;  end
      4'd4:  begin l44 = 11'd208;  l48 = 11'd192;  l32 = 11'd288;  end
      4'd5:  begin l44 = 11'd261;  l48 = 11'd240;  l32 = 11'd360;  end
      4'd6:  begin l44 = 11'd313;  l48 = 11'd288;  l32 = 11'd432;  end
      4'd7:  begin l44 = 11'd365;  l48 = 11'd336;  l32 = 11'd504;  end
      4'd8:  begin l44 = 11'd417;  l48 = 11'd384;  l32 = 11'd576;  end
      4'd9:  begin l44 = 11'd522;  l48 = 11'd480;  l32 = 11'd720;  end
      4'd10: begin l44 = 11'd626;  l48 = 11'd576;  l32 = 11'd864;  end
      4'd11: begin l44 = 11'd731;  l48 = 11'd672;  l32 = 11'd1008; end
      4'd12: begin l44 = 11'd835;  l48 = 11'd768;  l32 = 11'd1152; end
      4'd13: begin l44 = 11'd1044; l48 = 11'd960;  l32 = 11'd1440; end
      4'd14: begin l44 = 11'd1253; l48 = 11'd1152; l32 = 11'd1728; end
      default: begin l44 = 11'd0; l48 = 11'd0; l32 = 11'd0; end
    endcase
    case (rc)
      2'd0:    frame_len = l44;
      2'd1:    frame_len = l48;
      2'd2:    frame_len = l32;
      default: frame_len = 11'd0;
    endcase
  endfunction

  function automatic logic [2:0] fmt_sel(input logic stereo, input logic [1:0] rc,
                                         input logic [3:0] br);
    logic [3:0] hi_lo;
    hi_lo = stereo ? 4'd6 : 4'd2;
    fmt_sel = 3'd0;
    if (br == 4'd15 || rc == 2'd3) begin
      fmt_sel = 3'd0;
    end else if (br == 4'd0) begin
      fmt_sel = (rc == 2'd1) ? 3'd1 : 3'd2;
    end else if (br <= 4'd2 || (stereo && br <= hi_lo)) begin
      fmt_sel = (rc == 2'd2) ? 3'd4 : 3'd3;
    end else if (br <= hi_lo + 4'd3 || rc == 2'd1) begin
      fmt_sel = 3'd1;
    end else begin
      fmt_sel = 3'd2;
    end
  endfunction

  function automatic logic [4:0] fmt_nsub(input logic [2:0] fc);
    case (fc)
      3'd1:    fmt_nsub = 5'd27;
      3'd2:    fmt_nsub = 5'd30;
      3'd3:    fmt_nsub = 5'd8;
      3'd4:    fmt_nsub = 5'd12;
      default: fmt_nsub = 5'd0;
    endcase
  endfunction

  function automatic logic [2:0] band_class(input logic [2:0] fc, input logic [4:0] band);
    band_class = 3'd0;
    case (fc)
      3'd1, 3'd2: begin
        if (band <= 5'd2)       band_class = 3'd1;
        else if (band <= 5'd10) band_class = 3'd2;
        else if (band <= 5'd22) band_class = 3'd4;
        else if (band < fmt_nsub(fc)) band_class = 3'd6;
      end
      3'd3, 3'd4: begin
        if (band <= 5'd1)       band_class = 3'd3;
        else if (band < fmt_nsub(fc)) band_class = 3'd5;
      end
      default: band_class = 3'd0;
    endcase
  endfunction

  function automatic logic [4:0] nbal(input logic [2:0] bc);
    case (bc)
      3'd1, 3'd2, 3'd3: nbal = 5'd4;
      3'd4, 3'd5:       nbal = 5'd3;
      3'd6:             nbal = 5'd2;
      default:          nbal = 5'd0;
    endcase
  endfunction

  function automatic logic [4:0] qidx(input logic [2:0] bc, input logic [3:0] code);
    logic [4:0] c;
    c = {1'b0, code};
    case (bc)
      3'd1:    qidx = (code <= 4'd1) ? c : (code == 4'd2) ? 5'd3 : c + 5'd2;
      3'd2:    qidx = (code == 4'd15) ? 5'd17 : c;
      3'd3:    qidx = (code <= 4'd2) ? c : c + 5'd1;
      3'd4:    qidx = (code == 4'd7) ? 5'd17 : c;
      3'd5:    qidx = (code <= 4'd2) ? c : c + 5'd1;
      3'd6:    qidx = (code == 4'd3) ? 5'd17 : c;
      default: qidx = 5'd0;
    endcase
  endfunction

  function automatic logic [1:0] scale_count(input logic [1:0] sf);
    case (sf)
      2'd0:    scale_count = 2'd3;
      2'd2:    scale_count = 2'd1;
      default: scale_count = 2'd2;
    endcase
  endfunction

  function automatic logic [4:0] bound_of(input logic [1:0] mode, input logic [1:0] ext,
                                          input logic [4:0] nsub);
    logic [4:0] b;
    b = {3'(ext) + 3'd1, 2'b00};
    if (mode == MODE_MONO)       bound_of = 5'd0;
    else if (mode == MODE_JOINT) bound_of = (b < nsub) ? b : nsub;
    else                         bound_of = nsub;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mp2p_in_if.sv -----
// ----------------------------------------------------------------------------
// mp2p_in_if
// Byte stream channel into the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mp2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink (input valid, input frame_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- hdl/mp2p_out_if.sv -----
// ----------------------------------------------------------------------------
// mp2p_out_if
// Record channel out of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mp2p_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [10:0] frame_bytes;
  logic [1:0]  stereo_mode;
  logic [4:0]  subband_count;
  logic [4:0]  intensity_bound;
  logic [4:0]  band_index;
  logic        channel_index;
  logic [4:0]  quant_class;
  logic [5:0]  scale_first;
  logic [5:0]  scale_second;
  logic [5:0]  scale_third;
  logic        last;

  modport source (output valid, output record_kind, output frame_bytes, output stereo_mode,
                  output subband_count, output intensity_bound, output band_index,
                  output channel_index, output quant_class, output scale_first,
                  output scale_second, output scale_third, output last, input ready);
  modport sink (input valid, input record_kind, input frame_bytes, input stereo_mode,
                input subband_count, input intensity_bound, input band_index,
                input channel_index, input quant_class, input scale_first,
                input scale_second, input scale_third, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/mp2_header_side_info_parser_top.sv -----
// ----------------------------------------------------------------------------
// mp2_header_side_info_parser_top
// MPEG-1 Layer II header and side-info parser, byte in, records out.
// ----------------------------------------------------------------------------
// Takes one frame byte per transfer and works through it one bit per clock
// while no record is stalled on the output: a byte goes through the transfer,
// a step for each bit and a closing check, plus a settling step after each
// completed field and for each unallocated band that is passed over. Byte
// rate is set by the single-bit shifter feeding the field extractor. A header
// record follows the header, then one band record per subband and channel; a
// bad sync, version, layer or rate, or a stereo mode with one channel, gives
// an error record and the rest of the frame is ignored until frame_start.
`timescale 1ns / 1ps
`default_nettype none

module mp2_header_side_info_parser_top import mp2p_pkg::*; #(
  parameter int MAX_BANDS    = 32,
  parameter int MAX_CHANNELS = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mp2p_in_if.sink    frames,
  mp2p_out_if.source records
);

  cmd_t  cmd;
  stat_t stat;
  rec_t  rec;
  logic  rec_valid;

  mp2p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frames.valid),
    .in_ready  (frames.ready),
    .out_ready (records.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mp2p_dpath #(.MAX_BANDS(MAX_BANDS), .MAX_CHANNELS(MAX_CHANNELS)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .frame_byte  (frames.frame_byte),
    .frame_start (frames.frame_start),
    .out_ready   (records.ready),
    .stat        (stat),
    .rec         (rec),
    .rec_valid   (rec_valid)
  );

  assign records.valid           = rec_valid;
  assign records.record_kind     = rec.record_kind;
  assign records.frame_bytes     = rec.frame_bytes;
  assign records.stereo_mode     = rec.stereo_mode;
  assign records.subband_count   = rec.subband_count;
  assign records.intensity_bound = rec.intensity_bound;
  assign records.band_index      = rec.band_index;
  assign records.channel_index   = rec.channel_index;
  assign records.quant_class     = rec.quant_class;
  assign records.scale_first     = rec.scale_first;
  assign records.scale_second    = rec.scale_second;
  assign records.scale_third     = rec.scale_third;
  assign records.last            = rec.last;

endmodule

`default_nettype wire

// ----- hdl/mp2p_ram.sv -----
// ----------------------------------------------------------------------------
// mp2p_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/mp2p_ctrl.sv -----
// ----------------------------------------------------------------------------
// mp2p_ctrl
// Byte sequencer: takes a byte, then steps the datapath until it is used up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp2p_ctrl import mp2p_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_ACCEPT = 2'b01,
    S_WORK   = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_ACCEPT);

  always_comb begin
    cmd.load = in_ready && in_valid;
    // Step only when the output register can take a record.
    cmd.step = (state == S_WORK) && (!stat.rec_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_ACCEPT: begin
        if (in_valid) state_next = S_WORK;
      end
      S_WORK: begin
        if (cmd.step && stat.done) state_next = S_ACCEPT;
      end
      default: state_next = S_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  a_load_to_work: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_WORK) else $error("load did not start work");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (stat.rec_valid && !out_ready) |-> !cmd.step) else $error("step while record stalled");
  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.step) else $error("step while waiting for a byte");

endmodule

`default_nettype wire

// ----- hdl/mp2p_dpath.sv -----
// ----------------------------------------------------------------------------
// mp2p_dpath
// Bit-serial field extractor, parse phase, side-info stores and the record
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp2p_dpath import mp2p_pkg::*; #(
  parameter int MAX_BANDS    = 32,
  parameter int MAX_CHANNELS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] frame_byte,
  input  wire logic       frame_start,
  input  wire logic       out_ready,
  output stat_t           stat,
  output rec_t            rec,
  output logic            rec_valid
);

  localparam int AW = $clog2(MAX_BANDS);

  typedef enum logic [7:0] {
    PH_SYNC  = 8'b0000_0001,
    PH_HDRA  = 8'b0000_0010,
    PH_HDRB  = 8'b0000_0100,
    PH_CRC   = 8'b0000_1000,
    PH_ALLOC = 8'b0001_0000,
    PH_SCFSI = 8'b0010_0000,
    PH_SCALE = 8'b0100_0000,
    PH_IDLE  = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] bit_buffer, bit_buffer_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [7:0]  shreg, shreg_next;
  logic [3:0]  bits_left, bits_left_next;
  logic        settle_pend, settle_pend_next;
  logic [3:0]  br, br_next;
  logic [1:0]  rc, rc_next;
  logic        pad, pad_next;
  logic [1:0]  mode, mode_next;
  logic [1:0]  ext, ext_next;
  logic        crc_bit, crc_bit_next;
  logic [2:0]  format_class, format_class_next;
  logic [4:0]  band, band_next;
  logic        ch, ch_next;
  logic [1:0]  sf_pos, sf_pos_next;
  logic [5:0]  sf_hold [3];
  logic [5:0]  sf_hold_next [3];
  rec_t        rec_next;
  logic        rec_valid_next;

  logic [4:0]  alloc_q [MAX_CHANNELS];
  logic [1:0]  scfsi_q [MAX_CHANNELS];
  logic        alloc_we [MAX_CHANNELS];
  logic        scfsi_we [MAX_CHANNELS];
  logic [4:0]  alloc_wdata;
  logic [1:0]  scfsi_wdata;
  logic [AW-1:0] rd_addr;

  logic [4:0]  cur_alloc;
  logic [1:0]  cur_scfsi;
  logic [4:0]  nsub;
  logic        chans2;
  logic [4:0]  bound;
  logic [2:0]  bclass;
  logic [4:0]  need;
  logic        wrap;
  logic [4:0]  adv_band;
  logic        adv_ch;
  logic        adv_done;
  logic        is_last;

  assign cur_alloc = (MAX_CHANNELS > 1 && ch) ? alloc_q[MAX_CHANNELS-1] : alloc_q[0];
  assign cur_scfsi = (MAX_CHANNELS > 1 && ch) ? scfsi_q[MAX_CHANNELS-1] : scfsi_q[0];
  assign nsub      = fmt_nsub(format_class);
  assign chans2    = (mode != MODE_MONO);
  assign bound     = bound_of(mode, ext, nsub);
  assign bclass    = band_class(format_class, band);

  // Unshared advance to the next band/channel slot.
  assign wrap     = !chans2 || ch;
  assign adv_band = wrap ? band + 5'd1 : band;
  assign adv_ch   = wrap ? 1'b0 : 1'b1;
  assign adv_done = (adv_band >= nsub);
  assign is_last  = (band + 5'd1 == nsub) && (ch == chans2);

  always_comb begin
    case (phase)
      PH_SYNC:  need = 5'd11;
      PH_HDRA:  need = 5'd5;
      PH_HDRB:  need = 5'd16;
      PH_CRC:   need = 5'd16;
      PH_ALLOC: need = nbal(bclass);
      PH_SCFSI: need = (cur_alloc != 5'd0) ? 5'd2 : 5'd0;
      PH_SCALE: need = (cur_alloc != 5'd0) ? 5'd6 : 5'd0;
      default:  need = 5'd0;
    endcase
  end

  always_comb begin
    logic [15:0] v;
    logic        shared;
    logic [4:0]  sh_band;
    logic        sh_ch;
    logic [2:0]  fc;
    logic [5:0]  s;
    logic [5:0]  h [3];

    phase_next        = phase;
    bit_buffer_next   = bit_buffer;
    bit_count_next    = bit_count;
    shreg_next        = shreg;
    bits_left_next    = bits_left;
    settle_pend_next  = settle_pend;
    br_next           = br;
    rc_next           = rc;
    pad_next          = pad;
    mode_next         = mode;
    ext_next          = ext;
    crc_bit_next      = crc_bit;
    format_class_next = format_class;
    band_next         = band;
    ch_next           = ch;
    sf_pos_next       = sf_pos;
    sf_hold_next      = sf_hold;
    rec_next          = rec;
    rec_valid_next    = rec_valid && !out_ready;
    alloc_wdata       = 5'd0;
    scfsi_wdata       = 2'd0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      alloc_we[c] = 1'b0;
      scfsi_we[c] = 1'b0;
    end
    v       = {bit_buffer[14:0], shreg[7]};
    shared  = chans2 && (band >= bound);
    sh_band = (shared || wrap) ? band + 5'd1 : band;
    sh_ch   = (shared || wrap) ? 1'b0 : 1'b1;
    fc      = fmt_sel(v[7:6] != MODE_MONO, v[11:10], v[15:12]);
    s       = v[5:0];
    h       = sf_hold;

    if (cmd.load) begin
      shreg_next     = frame_byte;
      bits_left_next = 4'd8;
      if (frame_start) begin
        bit_buffer_next = 16'd0;
        bit_count_next  = 5'd0;
        phase_next      = PH_SYNC;
        br_next         = 4'd0;
        rc_next         = 2'd0;
        pad_next        = 1'b0;
        mode_next       = 2'd0;
        ext_next        = 2'd0;
        crc_bit_next    = 1'b0;
        band_next       = 5'd0;
        ch_next         = 1'b0;
        sf_pos_next     = 2'd0;
        for (int i = 0; i < 3; i++) sf_hold_next[i] = 6'd0;
      end
    end else if (cmd.step) begin
      if (settle_pend) begin
        // Pass over unallocated bands one slot a step.
        if (phase == PH_SCFSI && cur_alloc == 5'd0) begin
          band_next = adv_band;
          ch_next   = adv_ch;
          if (adv_done) begin
            phase_next  = PH_SCALE;
            band_next   = 5'd0;
            ch_next     = 1'b0;
            sf_pos_next = 2'd0;
          end
        end else if (phase == PH_SCALE && cur_alloc == 5'd0) begin
          rec_next               = '0;
          rec_next.record_kind   = REC_BAND;
          rec_next.band_index    = band;
          rec_next.channel_index = ch;
          rec_next.last          = is_last;
          rec_valid_next         = 1'b1;
          band_next              = adv_band;
          ch_next                = adv_ch;
          if (adv_done) phase_next = PH_IDLE;
        end else begin
          settle_pend_next = 1'b0;
        end
      end else if (bits_left != 4'd0) begin
        bits_left_next = bits_left - 4'd1;
        shreg_next     = {shreg[6:0], 1'b0};
        if (phase != PH_IDLE) begin
          if (need == 5'd0) begin
            // Drop this bit.
            settle_pend_next = 1'b1;
          end else if (bit_count + 5'd1 < need) begin
            bit_buffer_next = v;
            bit_count_next  = bit_count + 5'd1;
          end else begin
            bit_buffer_next  = 16'd0;
            bit_count_next   = 5'd0;
            settle_pend_next = 1'b1;
            case (phase)
              PH_SYNC: begin
                if (v[10:0] == 11'h7FF) begin
                  phase_next = PH_HDRA;
                end else begin
                  rec_next             = '0;
                  rec_next.record_kind = REC_ERROR;
                  rec_next.last        = 1'b1;
                  rec_valid_next       = 1'b1;
                  phase_next           = PH_IDLE;
                end
              end
              PH_HDRA: begin
                if (v[4:3] != 2'd3 || v[2:1] != 2'd2) begin
                  rec_next             = '0;
                  rec_next.record_kind = REC_ERROR;
                  rec_next.last        = 1'b1;
                  rec_valid_next       = 1'b1;
                  phase_next           = PH_IDLE;
                end else begin
                  crc_bit_next = v[0];
                  br_next      = 4'd0;
                  rc_next      = 2'd0;
                  pad_next     = 1'b0;
                  mode_next    = 2'd0;
                  ext_next     = 2'd0;
                  phase_next   = PH_HDRB;
                end
              end
              PH_HDRB: begin
                br_next   = v[15:12];
                rc_next   = v[11:10];
                pad_next  = v[9];
                mode_next = v[7:6];
                ext_next  = v[5:4];
                if (v[15:12] == 4'd0 || v[15:12] == 4'd15 || v[11:10] == 2'd3 ||
                    (v[7:6] != MODE_MONO && MAX_CHANNELS < 2)) begin
                  rec_next             = '0;
                  rec_next.record_kind = REC_ERROR;
                  rec_next.last        = 1'b1;
                  rec_valid_next       = 1'b1;
                  phase_next           = PH_IDLE;
                end else begin
                  format_class_next        = fc;
                  rec_next                 = '0;
                  rec_next.record_kind     = REC_HEADER;
                  rec_next.frame_bytes     = frame_len(v[11:10], v[15:12]) + 11'(v[9]);
                  rec_next.stereo_mode     = v[7:6];
                  rec_next.subband_count   = fmt_nsub(fc);
                  rec_next.intensity_bound = bound_of(v[7:6], v[5:4], fmt_nsub(fc));
                  rec_valid_next           = 1'b1;
                  phase_next               = crc_bit ? PH_ALLOC : PH_CRC;
                  band_next                = 5'd0;
                  ch_next                  = 1'b0;
                  sf_pos_next              = 2'd0;
                end
              end
              PH_CRC: begin
                phase_next  = PH_ALLOC;
                band_next   = 5'd0;
                ch_next     = 1'b0;
                sf_pos_next = 2'd0;
              end
              PH_ALLOC: begin
                alloc_wdata = qidx(bclass, v[3:0]);
                for (int c = 0; c < MAX_CHANNELS; c++) begin
                  alloc_we[c] = shared || (ch == 1'(c));
                end
                band_next = sh_band;
                ch_next   = sh_ch;
                if (sh_band >= nsub) begin
                  phase_next  = PH_SCFSI;
                  band_next   = 5'd0;
                  ch_next     = 1'b0;
                  sf_pos_next = 2'd0;
                end
              end
              PH_SCFSI: begin
                scfsi_wdata = v[1:0];
                for (int c = 0; c < MAX_CHANNELS; c++) begin
                  scfsi_we[c] = (ch == 1'(c));
                end
                band_next = adv_band;
                ch_next   = adv_ch;
                if (adv_done) begin
                  phase_next  = PH_SCALE;
                  band_next   = 5'd0;
                  ch_next     = 1'b0;
                  sf_pos_next = 2'd0;
                end
              end
              PH_SCALE: begin
                // Expand per scfsi: shared thirds take the same index.
                case (cur_scfsi)
                  2'd0: begin
                    if (sf_pos == 2'd0)      h[0] = s;
                    else if (sf_pos == 2'd1) h[1] = s;
                    else                     h[2] = s;
                  end
                  2'd1: begin
                    if (sf_pos == 2'd0) begin
                      h[0] = s;
                      h[1] = s;
                    end else begin
                      h[2] = s;
                    end
                  end
                  2'd2: begin
                    h[0] = s;
                    h[1] = s;
                    h[2] = s;
                  end
                  default: begin
                    if (sf_pos == 2'd0) begin
                      h[0] = s;
                    end else begin
                      h[1] = s;
                      h[2] = s;
                    end
                  end
                endcase
                sf_hold_next = h;
                if (sf_pos + 2'd1 >= scale_count(cur_scfsi)) begin
                  rec_next               = '0;
                  rec_next.record_kind   = REC_BAND;
                  rec_next.band_index    = band;
                  rec_next.channel_index = ch;
                  rec_next.quant_class   = cur_alloc;
                  rec_next.scale_first   = h[0];
                  rec_next.scale_second  = h[1];
                  rec_next.scale_third   = h[2];
                  rec_next.last          = is_last;
                  rec_valid_next         = 1'b1;
                  sf_pos_next            = 2'd0;
                  band_next              = adv_band;
                  ch_next                = adv_ch;
                  if (adv_done) phase_next = PH_IDLE;
                end else begin
                  sf_pos_next = sf_pos + 2'd1;
                end
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
        end
      end
    end
  end

  // Read the slot that will be current next cycle.
  assign rd_addr = (32'(band_next) < MAX_BANDS) ? band_next[AW-1:0] : '0;

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_store
    mp2p_ram #(.WIDTH(5), .DEPTH(MAX_BANDS)) u_alloc (
      .clk   (clk),
      .we    (alloc_we[g]),
      .waddr (band[AW-1:0]),
      .wdata (alloc_wdata),
      .raddr (rd_addr),
      .rdata (alloc_q[g])
    );
    mp2p_ram #(.WIDTH(2), .DEPTH(MAX_BANDS)) u_scfsi (
      .clk   (clk),
      .we    (scfsi_we[g]),
      .waddr (band[AW-1:0]),
      .wdata (scfsi_wdata),
      .raddr (rd_addr),
      .rdata (scfsi_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC;
      bit_buffer   <= 16'd0;
      bit_count    <= 5'd0;
      bits_left    <= 4'd0;
      settle_pend  <= 1'b0;
      br           <= 4'd0;
      rc           <= 2'd0;
      pad          <= 1'b0;
      mode         <= 2'd0;
      ext          <= 2'd0;
      crc_bit      <= 1'b0;
      format_class <= 3'd0;
      band         <= 5'd0;
      ch           <= 1'b0;
      sf_pos       <= 2'd0;
      for (int i = 0; i < 3; i++) sf_hold[i] <= 6'd0;
      rec_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      bit_buffer   <= bit_buffer_next;
      bit_count    <= bit_count_next;
      bits_left    <= bits_left_next;
      settle_pend  <= settle_pend_next;
      br           <= br_next;
      rc           <= rc_next;
      pad          <= pad_next;
      mode         <= mode_next;
      ext          <= ext_next;
      crc_bit      <= crc_bit_next;
      format_class <= format_class_next;
      band         <= band_next;
      ch           <= ch_next;
      sf_pos       <= sf_pos_next;
      sf_hold      <= sf_hold_next;
      rec_valid    <= rec_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    rec   <= rec_next;
  end

  assign stat.done      = (bits_left == 4'd0) && !settle_pend;
  assign stat.rec_valid = rec_valid;

  a_settle_holds_bits: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && settle_pend) |=> bits_left == $past(bits_left))
    else $error("settle step consumed a bit");
  a_band_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ALLOC || phase == PH_SCFSI || phase == PH_SCALE) |-> band < nsub)
    else $error("band position past subband count");
  a_mono_one_channel: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_ALLOC || phase == PH_SCFSI || phase == PH_SCALE) && mode == MODE_MONO)
      |-> !ch)
    else $error("second channel selected in mono frame");

endmodule

`default_nettype wire
